// ----- src/hed_pkg.sv -----
// Shared types and constants of the HTML character reference decoder.
package hed_pkg;

    // Width of a span length or index into the span buffer
    localparam int LEN_W      = 6;
    // Depth of the request queue between front and back
    localparam int CMDQ_DEPTH = 4;

    // Scanner mode of the front part
    typedef enum logic [1:0] {
        SCAN_PASS,
        SCAN_HOLD,
        SCAN_RAW
    } t_scan_mode;

    // Sequencer state of the back part
    typedef enum logic [1:0] {
        B_IDLE,
        B_FLUSH_RD,
        B_FLUSH_WR,
        B_EMIT
    } t_back_state;

    // What a request asks the back part to emit
    typedef enum logic [1:0] {
        CMD_BYTE,
        CMD_CODE,
        CMD_FLUSH
    } t_cmd_kind;

    // One request: a single byte, a code point, or a held span plus a tail byte
    typedef struct packed {
        t_cmd_kind        kind;
        logic [7:0]       data;
        logic [20:0]      cp;
        logic [LEN_W-1:0] len;
    } t_cmd;

    // Write port of the span buffer
    typedef struct packed {
        logic             en;
        logic [LEN_W-1:0] addr;
        logic [7:0]       data;
    } t_span_wr;

endpackage

// ----- src/hed_if.sv -----
// Valid/ready channels of the decoder: input text and decoded output.
interface hed_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, text_byte, end_of_text, input ready);
    modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

interface hed_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, out_byte, last_of_run, input ready);
    modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface

// ----- src/hed_cmd_fifo.sv -----
// Short request queue between the front scanner and the back emitter.
module hed_cmd_fifo
    import hed_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    localparam int PW = $clog2(CMDQ_DEPTH);

    t_cmd          r_mem [CMDQ_DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [PW:0]   r_count;

    assign o_full  = (r_count == (PW+1)'(CMDQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= r_wptr + PW'(1);
            if (i_pop)  r_rptr <= r_rptr + PW'(1);
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (PW+1)'(1);
                2'b01:   r_count <= r_count - (PW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_cmd;
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("request pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("request popped from an empty queue");

endmodule

// ----- src/hed_front.sv -----
// Front scanner: takes text bytes, holds spans, parses references, issues requests.
module hed_front
    import hed_pkg::*;
#(
    parameter int SPAN_MAX = 62
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    hed_in_if.sink   i_in,
    input  logic     i_q_full,
    input  logic     i_flush_done,
    output logic     o_q_push,
    output t_cmd     o_q_cmd,
    output t_span_wr o_span_wr
);

    localparam int NAME_N = 5;
    // lt, gt, amp, quot, apos, left-aligned
    localparam logic [31:0] NAME_STR [NAME_N] = '{
        32'h6C74_0000, 32'h6774_0000, 32'h616D_7000, 32'h7175_6F74, 32'h6170_6F73};
    localparam logic [LEN_W-1:0] NAME_LEN [NAME_N] = '{
        LEN_W'(2), LEN_W'(2), LEN_W'(3), LEN_W'(4), LEN_W'(4)};
    localparam logic [7:0] NAME_OUT [NAME_N] = '{8'h3C, 8'h3E, 8'h26, 8'h22, 8'h27};

    localparam logic [7:0]  CH_AMP   = 8'h26;
    localparam logic [7:0]  CH_SEMI  = 8'h3B;
    localparam logic [7:0]  CH_HASH  = 8'h23;
    localparam logic [7:0]  CH_X_LO  = 8'h78;
    localparam logic [7:0]  CH_X_UP  = 8'h58;
    localparam logic [31:0] CP_MAX   = 32'h0010_FFFF;
    localparam logic [31:0] SURR_LO  = 32'h0000_D800;
    localparam logic [31:0] SURR_HI  = 32'h0000_DFFF;
    localparam logic [20:0] CP_REPL  = 21'h00FFFD;

    t_scan_mode        r_mode, n_mode;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [NAME_N-1:0] r_nm, n_nm;
    logic              r_num_ok, n_num_ok;
    logic              r_hex, n_hex;
    logic              r_has_dig, n_has_dig;
    logic [31:0]       r_code, n_code;
    logic              r_ovf, n_ovf;
    logic              r_flush_busy, n_flush_busy;

    logic              w_accept;
    logic [7:0]        w_b;
    logic              w_eot;
    logic [LEN_W-1:0]  w_pm1;
    logic [NAME_N-1:0] w_nm_step;
    logic              w_is_dec;
    logic              w_is_hex;
    logic [3:0]        w_dval;
    logic              w_dig_ok;
    logic [35:0]       w_prod;
    logic              w_name_hit;
    logic [7:0]        w_name_char;
    logic              w_num_valid;
    logic              w_cp_bad;

    assign i_in.ready = !r_flush_busy && !i_q_full;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_b        = i_in.text_byte;
    assign w_eot      = i_in.end_of_text;
    assign w_pm1      = r_len - LEN_W'(1);

    // name prefix tracking, one flag per name
    always_comb begin
        for (int k = 0; k < NAME_N; k++) begin
            w_nm_step[k] = r_nm[k] && (r_len != '0) && (r_len <= NAME_LEN[k]) &&
                           (w_b == NAME_STR[k][31 - 8*int'(w_pm1[1:0]) -: 8]);
        end
    end

    // digit classification and value accumulation
    always_comb begin
        w_is_dec = (w_b >= 8'h30) && (w_b <= 8'h39);
        w_is_hex = w_is_dec || ((w_b >= 8'h61) && (w_b <= 8'h66)) ||
                   ((w_b >= 8'h41) && (w_b <= 8'h46));
        if (w_is_dec)          w_dval = w_b[3:0];
        else                   w_dval = w_b[3:0] + 4'd9;
        w_dig_ok = r_hex ? w_is_hex : w_is_dec;
        if (r_hex) w_prod = {r_code, 4'b0000} + {32'b0, w_dval};
        else       w_prod = {1'b0, r_code, 3'b000} + {3'b000, r_code, 1'b0} + {32'b0, w_dval};
    end

    // reference resolution at the semicolon
    always_comb begin
        w_name_hit  = 1'b0;
        w_name_char = 8'h00;
        for (int k = NAME_N - 1; k >= 0; k--) begin
            if (r_nm[k] && (r_len == NAME_LEN[k] + LEN_W'(1))) begin
                w_name_hit  = 1'b1;
                w_name_char = NAME_OUT[k];
            end
        end
        w_num_valid = r_num_ok && r_has_dig && !r_ovf;
        w_cp_bad    = (r_code == '0) || (r_code > CP_MAX) ||
                      ((r_code >= SURR_LO) && (r_code <= SURR_HI));
    end

    // scanner next state and requests
    always_comb begin
        n_mode       = r_mode;
        n_len        = r_len;
        n_nm         = r_nm;
        n_num_ok     = r_num_ok;
        n_hex        = r_hex;
        n_has_dig    = r_has_dig;
        n_code       = r_code;
        n_ovf        = r_ovf;
        n_flush_busy = r_flush_busy;
        if (i_flush_done) n_flush_busy = 1'b0;
        o_q_push     = 1'b0;
        o_q_cmd      = '{kind: CMD_BYTE, data: w_b, cp: '0, len: r_len};
        o_span_wr    = '{en: 1'b0, addr: r_len, data: w_b};

        if (w_accept) begin
            unique case (r_mode)
                SCAN_HOLD: begin
                    if (w_b == CH_SEMI) begin
                        o_q_push = 1'b1;
                        if (w_name_hit) begin
                            o_q_cmd.kind = CMD_BYTE;
                            o_q_cmd.data = w_name_char;
                        end else if (w_num_valid) begin
                            o_q_cmd.kind = CMD_CODE;
                            o_q_cmd.cp   = w_cp_bad ? CP_REPL : r_code[20:0];
                        end else begin
                            o_q_cmd.kind = CMD_FLUSH;
                            n_flush_busy = 1'b1;
                        end
                        n_mode = SCAN_PASS;
                        n_len  = '0;
                    end else if (w_eot || (r_len >= LEN_W'(SPAN_MAX))) begin
                        // end of text or full buffer: give the span back raw
                        o_q_push     = 1'b1;
                        o_q_cmd.kind = CMD_FLUSH;
                        n_flush_busy = 1'b1;
                        n_mode       = w_eot ? SCAN_PASS : SCAN_RAW;
                        n_len        = '0;
                    end else begin
                        o_span_wr.en = 1'b1;
                        n_len        = r_len + LEN_W'(1);
                        n_nm         = w_nm_step;
                        if (r_len == LEN_W'(1)) begin
                            n_num_ok = (w_b == CH_HASH);
                        end else if ((r_len == LEN_W'(2)) &&
                                     ((w_b == CH_X_LO) || (w_b == CH_X_UP))) begin
                            n_hex = 1'b1;
                        end else begin
                            n_num_ok = r_num_ok && w_dig_ok;
                            if (w_dig_ok) begin
                                n_has_dig = 1'b1;
                                if (w_prod[35:32] != 4'h0) n_ovf = 1'b1;
                                else if (!r_ovf)           n_code = w_prod[31:0];
                            end
                        end
                    end
                end
                SCAN_RAW: begin
                    o_q_push = 1'b1;
                    if ((w_b == CH_SEMI) || w_eot) n_mode = SCAN_PASS;
                end
                default: begin
                    n_mode = SCAN_PASS;
                    if ((w_b == CH_AMP) && !w_eot) begin
                        o_span_wr.en   = 1'b1;
                        o_span_wr.addr = '0;
                        n_len          = LEN_W'(1);
                        n_mode         = SCAN_HOLD;
                        n_nm           = '1;
                        n_num_ok       = 1'b0;
                        n_hex          = 1'b0;
                        n_has_dig      = 1'b0;
                        n_code         = '0;
                        n_ovf          = 1'b0;
                    end else begin
                        o_q_push = 1'b1;
                    end
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= SCAN_PASS;
            r_len        <= '0;
            r_flush_busy <= 1'b0;
        end else begin
            r_mode       <= n_mode;
            r_len        <= n_len;
            r_flush_busy <= n_flush_busy;
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        r_nm      <= n_nm;
        r_num_ok  <= n_num_ok;
        r_hex     <= n_hex;
        r_has_dig <= n_has_dig;
        r_code    <= n_code;
        r_ovf     <= n_ovf;
    end

    a_no_write_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush_busy |-> !o_span_wr.en)
        else $error("span buffer written while a flush is still reading it");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(SPAN_MAX))
        else $error("span length beyond buffer depth");

    a_len_only_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != SCAN_HOLD) |-> (r_len == '0))
        else $error("span length left over outside a held span");

endmodule

// ----- src/hed_back.sv -----
// Back emitter: owns the span buffer and turns requests into output bytes.
module hed_back
    import hed_pkg::*;
#(
    parameter int SPAN_MAX = 62
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_empty,
    input  t_cmd      i_q_cmd,
    output logic      o_q_pop,
    input  t_span_wr  i_span_wr,
    output logic      o_flush_done,
    hed_out_if.source o_out
);

    localparam int AW = $clog2(SPAN_MAX);

    localparam logic [7:0] UTF_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF_LEAD3 = 8'hE0;
    localparam logic [7:0] UTF_LEAD4 = 8'hF0;
    localparam logic [7:0] UTF_CONT  = 8'h80;

    t_back_state      r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [LEN_W-1:0] r_idx, n_idx;
    logic [7:0]       r_mem [SPAN_MAX];
    logic [7:0]       r_rd_data;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_byte, n_out_byte;
    logic             r_out_last, n_out_last;

    logic             w_out_free;
    logic [2:0]       w_nb;
    logic [7:0]       w_emit_byte;
    logic             w_emit_last;

    // number of UTF-8 bytes of a code point
    function automatic logic [2:0] utf8_len(input logic [20:0] cp);
        if (cp <= 21'h00007F)      return 3'd1;
        else if (cp <= 21'h0007FF) return 3'd2;
        else if (cp <= 21'h00FFFF) return 3'd3;
        else                       return 3'd4;
    endfunction

    // byte k of the UTF-8 form of a code point that takes n bytes
    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] n,
                                              input logic [1:0] k);
        logic [7:0] b;
        b = cp[7:0];
        case (n)
            3'd2: b = (k == 2'd0) ? (UTF_LEAD2 | {3'b000, cp[10:6]}) :
                                    (UTF_CONT | {2'b00, cp[5:0]});
            3'd3: begin
                case (k)
                    2'd0:    b = UTF_LEAD3 | {4'h0, cp[15:12]};
                    2'd1:    b = UTF_CONT | {2'b00, cp[11:6]};
                    default: b = UTF_CONT | {2'b00, cp[5:0]};
                endcase
            end
            3'd4: begin
                case (k)
                    2'd0:    b = UTF_LEAD4 | {5'h00, cp[20:18]};
                    2'd1:    b = UTF_CONT | {2'b00, cp[17:12]};
                    2'd2:    b = UTF_CONT | {2'b00, cp[11:6]};
                    default: b = UTF_CONT | {2'b00, cp[5:0]};
                endcase
            end
            default: b = cp[7:0];
        endcase
        return b;
    endfunction

    assign w_out_free = !r_out_valid || o_out.ready;

    // byte of the current request in the emit step
    always_comb begin
        w_nb        = (r_cmd.kind == CMD_CODE) ? utf8_len(r_cmd.cp) : 3'd1;
        w_emit_byte = (r_cmd.kind == CMD_CODE) ? utf8_byte(r_cmd.cp, w_nb, r_idx[1:0])
                                               : r_cmd.data;
        w_emit_last = (r_idx == (LEN_W'(w_nb) - LEN_W'(1)));
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_idx        = r_idx;
        o_q_pop      = 1'b0;
        o_flush_done = 1'b0;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_byte   = r_out_byte;
        n_out_last   = r_out_last;

        unique case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    n_idx   = '0;
                    n_state = (i_q_cmd.kind == CMD_FLUSH) ? B_FLUSH_RD : B_EMIT;
                end
            end
            B_FLUSH_RD: begin
                n_state = B_FLUSH_WR;
            end
            B_FLUSH_WR: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_rd_data;
                    n_out_last  = 1'b0;
                    if ((r_idx + LEN_W'(1)) == r_cmd.len) begin
                        o_flush_done = 1'b1;
                        n_idx        = '0;
                        n_state      = B_EMIT;
                    end else begin
                        n_idx   = r_idx + LEN_W'(1);
                        n_state = B_FLUSH_RD;
                    end
                end
            end
            B_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = w_emit_byte;
                    n_out_last  = w_emit_last;
                    if (!w_emit_last) begin
                        n_idx = r_idx + LEN_W'(1);
                    end else if (!i_q_empty) begin
                        // chain straight into the next request
                        o_q_pop = 1'b1;
                        n_cmd   = i_q_cmd;
                        n_idx   = '0;
                        n_state = (i_q_cmd.kind == CMD_FLUSH) ? B_FLUSH_RD : B_EMIT;
                    end else begin
                        n_state = B_IDLE;
                    end
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // request and output payload
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    // span buffer, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_span_wr.en) r_mem[i_span_wr.addr[AW-1:0]] <= i_span_wr.data;
        if (r_state == B_FLUSH_RD) r_rd_data <= r_mem[r_idx[AW-1:0]];
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_byte    = r_out_byte;
    assign o_out.last_of_run = r_out_last;

    a_flush_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_FLUSH_RD) |-> (r_cmd.len != '0))
        else $error("flush of an empty span");

    a_flush_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == B_FLUSH_RD) || (r_state == B_FLUSH_WR)) |-> (r_cmd.kind == CMD_FLUSH))
        else $error("buffer read for a request that is not a flush");

endmodule

// ----- src/html_entity_decoder_utf8_top.sv -----
// Top level of the streaming HTML character reference decoder with UTF-8 output.
//
// Input channel i_in carries one text byte per request with an end_of_text flag;
// output channel o_out carries decoded bytes, last_of_run marking the final byte
// caused by one input byte. Both are valid/ready.
// Plain bytes pass through at one byte per cycle while the output takes them; a
// taken byte goes through the scanner, request queue, emit step and output register.
// From an ampersand, bytes are held in a SPAN_MAX-byte buffer and give no output
// until a semicolon, end of text or a full buffer resolves the span. A named or
// numeric reference gives one to four bytes at one byte per cycle while the output
// takes them. A span given back raw is read from the buffer byte by byte (address,
// then registered data); the input is held off until the last held byte is read.
// A four-entry request queue lets the scanner keep taking bytes while the
// output is stalled; when the queue fills, i_in.ready drops.
// Reset (synchronous, active low) returns to pass-through, empties the queue
// and drops o_out.valid; buffer contents are not cleared.
module html_entity_decoder_utf8_top
    import hed_pkg::*;
#(
    parameter int SPAN_MAX = 62
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hed_in_if.sink    i_in,
    hed_out_if.source o_out
);

    logic     w_q_push;
    t_cmd     w_q_cmd_in;
    logic     w_q_full;
    logic     w_q_pop;
    t_cmd     w_q_cmd_out;
    logic     w_q_empty;
    t_span_wr w_span_wr;
    logic     w_flush_done;

    // scanner
    hed_front #(.SPAN_MAX(SPAN_MAX)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_q_full     (w_q_full),
        .i_flush_done (w_flush_done),
        .o_q_push     (w_q_push),
        .o_q_cmd      (w_q_cmd_in),
        .o_span_wr    (w_span_wr)
    );

    // request queue
    hed_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_cmd   (w_q_cmd_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_cmd   (w_q_cmd_out),
        .o_empty (w_q_empty)
    );

    // emitter
    hed_back #(.SPAN_MAX(SPAN_MAX)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (w_q_empty),
        .i_q_cmd      (w_q_cmd_out),
        .o_q_pop      (w_q_pop),
        .i_span_wr    (w_span_wr),
        .o_flush_done (w_flush_done),
        .o_out        (o_out)
    );

endmodule

// ----- tb/sv/html_entity_decoder_utf8_top_tb.sv -----
// Testbench of the HTML character reference decoder: directed and random text, checked bytewise.
`timescale 1ns / 1ps

module html_entity_decoder_utf8_top_tb
    import hed_pkg::*;
();

    localparam int SPAN_MAX     = 62;
    localparam int RANDOM_ITEMS = 350;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_REPORTS  = 10;

    // Characters the decoder reacts to or produces
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_QUOT = 8'h22;
    localparam logic [7:0] CH_APOS = 8'h27;
    localparam logic [7:0] CH_X_LO = 8'h78;
    localparam logic [7:0] CH_X_UP = 8'h58;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_dec_byte;

    // Decoder model plus the store of decoded bytes still to arrive
    class entity_scoreboard;
        t_scan_mode mode;
        logic [7:0] held [SPAN_MAX];
        int         held_len;
        t_dec_byte  run_q[$];
        t_dec_byte  decoded_q[$];
        int         fails;

        function new();
            mode     = SCAN_PASS;
            held_len = 0;
            fails    = 0;
        endfunction

        function void put(logic [7:0] b);
            t_dec_byte e;
            e.data = b;
            e.last = 1'b0;
            run_q = {run_q, e};
        endfunction

        function void flush_held();
            for (int i = 0; i < held_len; i++) put(held[i]);
            held_len = 0;
        endfunction

        function bit held_is(string name);
            if (held_len != name.len() + 1) return 1'b0;
            for (int i = 0; i < name.len(); i++)
                if (held[i + 1] != name[i]) return 1'b0;
            return 1'b1;
        endfunction

        function int digit_value(logic [7:0] c);
            if (c >= "0" && c <= "9") return c - "0";
            if (c >= "a" && c <= "f") return c - "a" + 10;
            if (c >= "A" && c <= "F") return c - "A" + 10;
            return 99;
        endfunction

        // Numeric reference: value and whether it is well formed and fits in 32 bits
        function bit read_number(output logic [31:0] value);
            int pos;
            int base;
            int d;
            longint unsigned acc;
            bit ovf;
            pos   = 2;
            base  = 10;
            acc   = 0;
            ovf   = 1'b0;
            value = '0;
            if (held_len < 2 || held[1] != CH_HASH) return 1'b0;
            if (pos < held_len && (held[pos] == CH_X_LO || held[pos] == CH_X_UP)) begin
                base = 16;
                pos++;
            end
            if (pos >= held_len) return 1'b0;
            for (; pos < held_len; pos++) begin
                d = digit_value(held[pos]);
                if (d >= base) return 1'b0;
                if (acc * base + d > 64'hFFFF_FFFF) ovf = 1'b1;
                else if (!ovf) acc = acc * base + d;
            end
            value = acc[31:0];
            return !ovf;
        endfunction

        function void put_utf8(logic [31:0] cp);
            if (cp == 0 || cp > 32'h10FFFF || (cp >= 32'hD800 && cp <= 32'hDFFF))
                cp = 32'hFFFD;
            if (cp <= 32'h7F) begin
                put(cp[7:0]);
            end else if (cp <= 32'h7FF) begin
                put({3'b110, cp[10:6]});
                put({2'b10, cp[5:0]});
            end else if (cp <= 32'hFFFF) begin
                put({4'b1110, cp[15:12]});
                put({2'b10, cp[11:6]});
                put({2'b10, cp[5:0]});
            end else begin
                put({5'b11110, cp[20:18]});
                put({2'b10, cp[17:12]});
                put({2'b10, cp[11:6]});
                put({2'b10, cp[5:0]});
            end
        endfunction

        // Span closed by a semicolon
        function void resolve_span();
            logic [31:0] cp;
            if (held_is("lt"))        put(CH_LT);
            else if (held_is("gt"))   put(CH_GT);
            else if (held_is("amp"))  put(CH_AMP);
            else if (held_is("quot")) put(CH_QUOT);
            else if (held_is("apos")) put(CH_APOS);
            else if (read_number(cp)) put_utf8(cp);
            else begin
                flush_held();
                put(CH_SEMI);
            end
            held_len = 0;
        endfunction

        // Accepted input request: queue the bytes it decodes to
        function void take_text_byte(logic [7:0] b, logic eot);
            run_q.delete();
            case (mode)
                SCAN_HOLD: begin
                    if (b == CH_SEMI) begin
                        resolve_span();
                        mode = SCAN_PASS;
                    end else if (eot) begin
                        flush_held();
                        put(b);
                        mode = SCAN_PASS;
                    end else if (held_len < SPAN_MAX) begin
                        held[held_len] = b;
                        held_len++;
                    end else begin
                        flush_held();
                        put(b);
                        mode = SCAN_RAW;
                    end
                end
                SCAN_RAW: begin
                    put(b);
                    if (b == CH_SEMI || eot) mode = SCAN_PASS;
                end
                default: begin
                    mode = SCAN_PASS;
                    if (b == CH_AMP && !eot) begin
                        held[0]  = b;
                        held_len = 1;
                        mode     = SCAN_HOLD;
                    end else begin
                        put(b);
                    end
                end
            endcase
            if (run_q.size() > 0) run_q[run_q.size() - 1].last = 1'b1;
            decoded_q = {decoded_q, run_q};
        endfunction

        // Accepted output request against the oldest expected byte
        function void check_out_byte(logic [7:0] b, logic last);
            t_dec_byte e;
            if (decoded_q.size() == 0) begin
                fails++;
                if (fails <= MAX_REPORTS)
                    $display("unexpected output: byte %02h last %0b", b, last);
                return;
            end
            e = decoded_q.pop_front();
            if (b !== e.data || last !== e.last) begin
                fails++;
                if (fails <= MAX_REPORTS)
                    $display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                             e.data, e.last, b, last);
            end
        endfunction

        function int outstanding();
            return decoded_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    hed_in_if  u_in ();
    hed_out_if u_out ();

    html_entity_decoder_utf8_top #(
        .SPAN_MAX (SPAN_MAX)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (u_in),
        .o_out   (u_out)
    );

    entity_scoreboard sb;
    logic [7:0]       text_q[$];
    int               accepted;
    bit               steady;
    bit               hold_req;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #20_000_000;
        $display("html_entity_decoder_utf8_top_tb: errors");
        $finish;
    end

    // Output side: random stalls, one long hold-off on request
    initial begin
        u_out.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                u_out.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                u_out.ready <= steady || ($urandom_range(0, 99) >= 10);
            end
        end
    end

    // Output monitor
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && u_out.valid === 1'b1 && u_out.ready === 1'b1)
            sb.check_out_byte(u_out.out_byte, u_out.last_of_run);
    end

    // One input request, with an occasional idle cycle before it
    task automatic send_byte(input logic [7:0] b, input logic eot);
        if (!steady && $urandom_range(0, 99) < 10) begin
            u_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        u_in.valid       <= 1'b1;
        u_in.text_byte   <= b;
        u_in.end_of_text <= eot;
        do @(posedge i_clk); while (u_in.ready !== 1'b1);
        sb.take_text_byte(b, eot);
        accepted++;
    endtask

    task automatic send_text(input bit eot_last);
        foreach (text_q[i]) send_byte(text_q[i], eot_last && i == text_q.size() - 1);
        text_q.delete();
    endtask

    // Stop offering and wait for every expected byte
    task automatic wait_drained();
        u_in.valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    function automatic void add_text_byte(logic [7:0] b);
        text_q = {text_q, b};
    endfunction

    function automatic void push_str(string s);
        for (int i = 0; i < s.len(); i++) add_text_byte(s[i]);
    endfunction

    function automatic logic [7:0] any_but_semi();
        logic [7:0] b;
        b = $urandom_range(0, 255);
        return (b == CH_SEMI) ? "a" : b;
    endfunction

    // Numeric reference across the UTF-8 length classes, invalid ranges and overflow
    function automatic void push_number();
        longint unsigned edges[] = '{64'h7F, 64'h80, 64'h7FF, 64'h800, 64'hD7FF, 64'hE000,
                                     64'hFFFF, 64'h10000, 64'h10FFFF, 64'h110000,
                                     64'hFFFF_FFFF, 64'h1_0000_0000};
        longint unsigned v;
        string digits;
        bit hex;
        int zeros;
        case ($urandom_range(0, 9))
            0:       v = 0;
            2:       v = $urandom_range(32'h80, 32'h7FF);
            3:       v = $urandom_range(32'h800, 32'hFFFF);
            4:       v = $urandom_range(32'hD800, 32'hDFFF);
            5:       v = $urandom_range(32'h10000, 32'h10FFFF);
            6:       v = $urandom_range(32'h110000, 32'hFFFF_FFFF);
            7:       v = edges[$urandom_range(0, edges.size() - 1)];
            8:       v = {$urandom, $urandom};
            default: v = $urandom_range(1, 127);
        endcase
        hex    = $urandom_range(0, 1);
        digits = hex ? $sformatf("%0h", v) : $sformatf("%0d", v);
        if (hex)
            for (int i = 0; i < digits.len(); i++)
                if (digits[i] >= "a" && $urandom_range(0, 1)) digits[i] = digits[i] - 8'h20;
        zeros = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(0, 2);
        push_str("&#");
        if (hex) push_str($urandom_range(0, 1) ? "x" : "X");
        repeat (zeros) add_text_byte("0");
        push_str(digits);
        push_str(";");
    endfunction

    // Named reference, sometimes slightly wrong
    function automatic void push_named();
        string names[] = '{"lt", "gt", "amp", "quot", "apos"};
        string n;
        n = names[$urandom_range(0, names.size() - 1)];
        case ($urandom_range(0, 9))
            0:       n[0] = n[0] - 8'h20;
            1:       n = n.substr(0, n.len() - 2);
            2:       n = {n, "s"};
            default: ;
        endcase
        push_str({"&", n, ";"});
    endfunction

    // Malformed reference: odd mix of digits, letters and markers
    function automatic void push_broken();
        string pool;
        pool = "#xX09afAFgz&<";
        push_str("&");
        repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 3) == 0) add_text_byte(any_but_semi());
            else add_text_byte(pool[$urandom_range(0, pool.len() - 1)]);
        end
        push_str(";");
    endfunction

    // Span around the buffer size: resolved when exactly full, flushed raw beyond
    function automatic void push_long_span();
        int lens[] = '{59, 60, 61, 62, 63, 70};
        int n;
        n = lens[$urandom_range(0, lens.size() - 1)];
        push_str("&");
        if ($urandom_range(0, 1)) begin
            push_str("#");
            repeat (n - 3) add_text_byte("0");
            push_str("65");
        end else begin
            repeat (n) add_text_byte(any_but_semi());
        end
        push_str("ab;");
    endfunction

    // Stimulus
    initial begin
        int seq;
        int base;
        int kind;
        int cut;
        sb               = new();
        accepted         = 0;
        steady           = 1'b0;
        hold_req         = 1'b0;
        i_rst_n          <= 1'b0;
        u_in.valid       <= 1'b0;
        u_in.text_byte   <= '0;
        u_in.end_of_text <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: byte extremes, ampersand inside a span, named, decimal,
        // surrogate, unknown name, unterminated span and lone ampersand at end
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        push_str("&&lt;&#233;&#xD800;&q;");
        send_text(1'b0);
        push_str("&g");
        send_text(1'b1);
        push_str("&");
        send_text(1'b1);

        // Random text built mostly from references
        base = accepted;
        seq  = 0;
        while (accepted < base + RANDOM_ITEMS) begin
            steady = (accepted >= base + 150 && accepted < base + 230);
            if (seq == 8) hold_req = 1'b1;
            if (seq == 60) wait_drained();
            kind = (seq == 3 || seq == 45) ? 18 : $urandom_range(0, 19);
            if (kind <= 5) begin
                repeat ($urandom_range(1, 5)) begin
                    case ($urandom_range(0, 7))
                        0:       send_byte(CH_AMP, $urandom_range(0, 19) == 0);
                        1:       send_byte(CH_SEMI, $urandom_range(0, 19) == 0);
                        default: send_byte($urandom_range(0, 255), $urandom_range(0, 19) == 0);
                    endcase
                end
            end else begin
                case (kind)
                    6, 7, 8:    push_named();
                    9, 10, 11:  push_number();
                    12, 13, 14: push_number();
                    15, 16, 17: push_broken();
                    18:         push_long_span();
                    default: begin
                        // cut short by the end of the text
                        if ($urandom_range(0, 1)) push_number(); else push_named();
                        cut    = $urandom_range(1, text_q.size() - 1);
                        text_q = text_q[0:cut - 1];
                    end
                endcase
                send_text(kind == 19 || $urandom_range(0, 15) == 0);
            end
            seq++;
        end
        steady = 1'b0;
        u_in.valid <= 1'b0;

        wait_drained();
        repeat (30) @(posedge i_clk);
        if (sb.fails == 0)
            $display("html_entity_decoder_utf8_top_tb: clean");
        else
            $display("html_entity_decoder_utf8_top_tb: errors");
        $finish;
    end

endmodule
